[src/rsts_pkg.sv]
// ----------------------------------------------------------------------------
// Range-sum tree package
// Shared constants for the range-sum tree with point set.
// ----------------------------------------------------------------------------
package rsts_pkg;

  // Default number of leaves of the tree.
  localparam int unsigned LEAVES_DEF = 1024;

  // Width of a stored value and of every partial sum.
  localparam int unsigned VAL_W = 64;

  // Operation codes carried by func_i.
  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

[src/rsts_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rsts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/rsts_walk.sv]
// ----------------------------------------------------------------------------
// Range-sum tree walker
// Sequencer that clears the node memory after reset, climbs from a leaf to the
// root on a set, and sweeps the range bounds up the tree on a query.
// ----------------------------------------------------------------------------
module rsts_walk #(
  parameter int unsigned LEAVES = rsts_pkg::LEAVES_DEF,
  localparam int unsigned TS_W  = $clog2(LEAVES),
  localparam int unsigned IDX_W = TS_W,
  localparam int unsigned RNG_W = $clog2(LEAVES + 1),
  localparam int unsigned NA_W  = TS_W + 1,
  localparam int unsigned VAL_W = rsts_pkg::VAL_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             func_i,
  input  logic [IDX_W-1:0] index_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic [RNG_W-1:0] left_i,
  input  logic [RNG_W-1:0] right_i,
  output logic             done_o,
  output logic [VAL_W-1:0] sum_o
);

  localparam int unsigned AE_W = NA_W + 1;
  localparam int unsigned TSPAN = 1 << TS_W;
  localparam logic [RNG_W-1:0] LEAVES_R = RNG_W'(LEAVES);
  localparam logic [IDX_W:0] LEAVES_I = (IDX_W + 1)'(LEAVES);
  localparam logic [NA_W-1:0] NODE_LAST = {NA_W{1'b1}};
  localparam logic [NA_W-1:0] NODE_ROOT = NA_W'(1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP,
    ST_QRY
  } state_e;

  state_e           state_q, state_d;
  logic [NA_W-1:0]  clr_q, clr_d;
  logic [NA_W-1:0]  node_q, node_d;
  logic [VAL_W-1:0] cur_q, cur_d;
  logic [AE_W-1:0]  a_q, a_d;
  logic [AE_W-1:0]  b_q, b_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic             pend_q, pend_d;

  logic             mem_we, mem_re;
  logic [NA_W-1:0]  mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;

  logic             accept;
  logic [NA_W-1:0]  leaf_node, parent;
  logic [VAL_W-1:0] up_sum;
  logic [RNG_W-1:0] hi;
  logic [AE_W-1:0]  b_init, a_init, a_inc, b_dec;

  rsts_ram #(
    .WIDTH (VAL_W),
    .DEPTH (2 * TSPAN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy_o    = (state_q != ST_IDLE);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign leaf_node = {1'b1, index_i};
  assign parent    = {1'b0, node_q[NA_W-1:1]};
  assign up_sum    = cur_q + mem_rdata;

  // The range is clipped to the leaves; an empty range starts with a equal to b.
  assign hi     = (right_i > LEAVES_R) ? LEAVES_R : right_i;
  assign b_init = AE_W'(hi) + AE_W'(TSPAN);
  assign a_init = (left_i >= hi) ? b_init : (AE_W'(left_i) + AE_W'(TSPAN));
  assign a_inc  = a_q + AE_W'(1);
  assign b_dec  = b_q - AE_W'(1);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    node_d    = node_q;
    cur_d     = cur_q;
    a_d       = a_q;
    b_d       = b_q;
    acc_d     = acc_q;
    pend_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    done_o    = 1'b0;
    sum_o     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + NA_W'(1);
        if (clr_q == NODE_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            rsts_pkg::FUNC_SET: begin
              // A leaf beyond LEAVES only exists as zero padding.
              if ({1'b0, index_i} < LEAVES_I) begin
                mem_we    = 1'b1;
                mem_waddr = leaf_node;
                mem_wdata = value_i;
                mem_re    = 1'b1;
                mem_raddr = leaf_node ^ NA_W'(1);
                node_d    = leaf_node;
                cur_d     = value_i;
                state_d   = ST_UP;
              end
            end
            rsts_pkg::FUNC_QUERY: begin
              a_d     = a_init;
              b_d     = b_init;
              acc_d   = '0;
              state_d = ST_QRY;
            end
            default: ;
          endcase
        end
      end

      ST_UP: begin
        // The sibling arrives now; the next sibling read never hits the parent.
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_sum;
        cur_d     = up_sum;
        node_d    = parent;
        if (parent == NODE_ROOT) begin
          state_d = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent ^ NA_W'(1);
        end
      end

      ST_QRY: begin
        acc_d = pend_q ? (acc_q + mem_rdata) : acc_q;
        if (a_q < b_q) begin
          priority if (a_q[0] && b_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = a_q[NA_W-1:0];
            pend_d    = 1'b1;
            a_d       = a_inc;
          end else if (a_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = a_q[NA_W-1:0];
            pend_d    = 1'b1;
            a_d       = a_inc >> 1;
            b_d       = b_q >> 1;
          end else if (b_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = b_dec[NA_W-1:0];
            pend_d    = 1'b1;
            a_d       = a_q >> 1;
            b_d       = b_dec >> 1;
          end else begin
            a_d = a_q >> 1;
            b_d = b_q >> 1;
          end
        end else begin
          done_o  = 1'b1;
          sum_o   = acc_d;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      node_q  <= '0;
      cur_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      node_q  <= node_d;
      cur_q   <= cur_d;
      a_q     <= a_d;
      b_q     <= b_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
    end
  end

endmodule

[src/range_sum_tree_point_set.sv]
// ----------------------------------------------------------------------------
// Range-sum tree with point set
// Binary tree of 64-bit wrapping partial sums over LEAVES leaves, kept in one
// synchronous RAM of 2*T words (T is LEAVES rounded up to a power of two).
//
// A transaction is accepted when start_i is high and busy_o is low. With
// func_i = 0 (set) it writes value_i into leaf index_i and rebuilds the sums on
// the path to the root; a set gives no result, and an index at or beyond
// LEAVES is ignored. With func_i = 1 (query) it returns the sum of the leaves
// in [left_i, right_i), clipped to the leaves, or zero for an empty range.
//
// A set keeps busy_o high while it does one RAM read-modify-write per tree
// level. A query keeps busy_o high while it sweeps the bounds up the tree;
// the RAM read port fetches at most one node per cycle and each level may
// need two. The result follows on total_o with a one-cycle valid_o strobe
// in the cycle in which busy_o falls. The receiver cannot stall, and a new
// transaction may be accepted while valid_o is high.
//
// After reset the block sweeps all 2*T RAM words to zero with busy_o high.
// ----------------------------------------------------------------------------
module range_sum_tree_point_set #(
  parameter int unsigned LEAVES = rsts_pkg::LEAVES_DEF,
  localparam int unsigned IDX_W = $clog2(LEAVES),
  localparam int unsigned RNG_W = $clog2(LEAVES + 1),
  localparam int unsigned VAL_W = rsts_pkg::VAL_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    func_i,
  input  logic [IDX_W-1:0]        index_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [RNG_W-1:0]        left_i,
  input  logic [RNG_W-1:0]        right_i,
  output logic                    valid_o,
  output logic signed [VAL_W-1:0] total_o
);

  logic             done;
  logic [VAL_W-1:0] sum;
  logic             valid_q;
  logic [VAL_W-1:0] total_q;

  rsts_walk #(
    .LEAVES (LEAVES)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .func_i  (func_i),
    .index_i (index_i),
    .value_i ($unsigned(value_i)),
    .left_i  (left_i),
    .right_i (right_i),
    .done_o  (done),
    .sum_o   (sum)
  );

  // Output register: the walker can take the next transaction at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      total_q <= sum;
    end
  end

  assign valid_o = valid_q;
  assign total_o = $signed(total_q);

endmodule
